// ----- rtl/lph_pkg.sv -----
package lph_pkg;

    // Fixed field widths of the ports.
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 64;
    localparam int KLEN_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int HASH_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int KEY_BYTES = KEY_W / BYTE_W;

    // Defaults for the top-level parameters.
    localparam int SLOTS_DEF         = 64;
    localparam int MAX_KEY_BYTES_DEF = 8;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    localparam logic [VALUE_W-1:0] NO_VALUE = {VALUE_W{1'b1}};

    // One slot of the table.
    typedef struct packed {
        logic                 used;
        logic [KLEN_W-1:0]    key_len;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
    } lph_entry_t;

endpackage

// ----- rtl/lph_hash_unit.sv -----
module lph_hash_unit #(
    parameter int SLOTS = lph_pkg::SLOTS_DEF,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lph_pkg::KEY_W-1:0]   key,
    input  logic [lph_pkg::KLEN_W-1:0]  key_len,
    output logic                        done,
    output logic [IDX_W-1:0]            home_idx
);
    import lph_pkg::*;

    localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    // Reciprocal of SLOTS scaled by 2^(HASH_W + IDX_W). The quotient estimate
    // (h * RECIP) >> RECIP_SHIFT is at most one below the true quotient.
    localparam int RECIP_W     = HASH_W + 1;
    localparam int PROD_W      = HASH_W + RECIP_W;
    localparam int RECIP_SHIFT = HASH_W + IDX_W;
    localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(SLOTS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [HASH_W-1:0] SLOTS_H = HASH_W'(SLOTS);
    localparam logic [IDX_W:0] SLOTS_X = (IDX_W + 1)'(SLOTS);

    typedef enum logic [4:0] {
        HU_IDLE = 5'b00001,
        HU_HASH = 5'b00010,
        HU_MUL  = 5'b00100,
        HU_SUB  = 5'b01000,
        HU_FIX  = 5'b10000
    } hu_state_t;

    hu_state_t           state_reg, state_next;
    logic [HASH_W-1:0]   h_reg, h_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [KLEN_W-1:0]   len_reg, len_next;
    logic [KLEN_W-1:0]   cnt_reg, cnt_next;
    logic [HASH_W-1:0]   q_reg, q_next;
    logic [IDX_W:0]      rem_reg, rem_next;
    logic [IDX_W-1:0]    home_reg, home_next;
    logic                done_reg, done_next;
    logic [PROD_W-1:0]   prod;
    logic [HASH_W-1:0]   remainder;
    logic [IDX_W:0]      fixed;

    // Modulo by reciprocal multiplication: the remainder after the estimated
    // quotient lies below twice SLOTS, so one compare and subtract finishes it.
    always_comb begin
        prod      = {{RECIP_W{1'b0}}, h_reg} * {{HASH_W{1'b0}}, RECIP};
        remainder = h_reg - q_reg * SLOTS_H;
        fixed     = (rem_reg >= SLOTS_X) ? (rem_reg - SLOTS_X) : rem_reg;
    end

    always_comb begin
        state_next = state_reg;
        h_next     = h_reg;
        key_next   = key_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        home_next  = home_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            HU_IDLE: begin
                if (start) begin
                    h_next     = '0;
                    key_next   = key;
                    len_next   = key_len;
                    cnt_next   = '0;
                    state_next = HU_HASH;
                end
            end
            HU_HASH: begin
                if (cnt_reg == len_reg) begin
                    if (SLOTS_POW2) begin
                        home_next  = h_reg[IDX_W-1:0];
                        done_next  = 1'b1;
                        state_next = HU_IDLE;
                    end else begin
                        state_next = HU_MUL;
                    end
                end else begin
                    // h * 31 + byte, wrapping at 32 bits.
                    h_next   = {h_reg[HASH_W-6:0], 5'b0} - h_reg
                               + {{(HASH_W-BYTE_W){1'b0}}, key_reg[BYTE_W-1:0]};
                    key_next = key_reg >> BYTE_W;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            HU_MUL: begin
                q_next     = HASH_W'(prod >> RECIP_SHIFT);
                state_next = HU_SUB;
            end
            HU_SUB: begin
                rem_next   = remainder[IDX_W:0];
                state_next = HU_FIX;
            end
            HU_FIX: begin
                home_next  = fixed[IDX_W-1:0];
                done_next  = 1'b1;
                state_next = HU_IDLE;
            end
            default: state_next = HU_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        h_reg    <= h_next;
        key_reg  <= key_next;
        len_reg  <= len_next;
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        home_reg <= home_next;
    end

    assign done     = done_reg;
    assign home_idx = home_reg;

endmodule

// ----- rtl/lph_slot_mem.sv -----
module lph_slot_mem #(
    parameter int SLOTS = lph_pkg::SLOTS_DEF,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  lph_pkg::lph_entry_t  wr_data,
    input  logic [IDX_W-1:0]     rd_addr,
    output lph_pkg::lph_entry_t  rd_data
);
    import lph_pkg::*;

    lph_entry_t mem [SLOTS];
    lph_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/linear_probe_hash_table_core.sv -----
// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  command, key bytes, key length, insert value
// m_        out        m_valid / m_ready  status, read value
//
// After reset a clearing pass marks every slot unused; no word is accepted.
// A word is accepted, its effective key bytes are hashed one by one (followed by multiply,
// subtract and correction steps when SLOTS is not a power of two), each probed slot is read
// and then checked, and the result is handed over; probing sets the overall time.
// Insert into a full table and the unused command skip hashing and go straight to the result.
// A result waits in the output register while the next word runs; only a second
// finished result that finds the first not yet taken stalls the block.
module linear_probe_hash_table_core #(
    parameter int SLOTS         = lph_pkg::SLOTS_DEF,
    parameter int MAX_KEY_BYTES = lph_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic        [lph_pkg::CMD_W-1:0]    s_command,
    input  logic        [lph_pkg::KEY_W-1:0]    s_key_bytes,
    input  logic        [lph_pkg::KLEN_W-1:0]   s_key_length,
    input  logic signed [lph_pkg::VALUE_W-1:0]  s_insert_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic        [lph_pkg::STATUS_W-1:0] m_status,
    output logic signed [lph_pkg::VALUE_W-1:0]  m_read_value
);
    import lph_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W:0]   COUNT_FULL = (IDX_W + 1)'(SLOTS);
    localparam logic [KLEN_W-1:0] KEY_LIMIT = KLEN_W'(MAX_KEY_BYTES);

    // Sequencer states.
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_READ  = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [KLEN_W-1:0]      len_reg, len_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       step_reg, step_next;
    logic [IDX_W:0]         count_reg, count_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [VALUE_W-1:0]     res_value_reg, res_value_next;
    logic                   m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;
    logic [VALUE_W-1:0]     m_value_reg, m_value_next;

    logic                   s_fire;
    logic [KLEN_W-1:0]      limit;
    logic [KEY_W-1:0]       shaped_key;
    logic [KLEN_W-1:0]      shaped_len;
    logic                   key_end;

    logic                   hash_start;
    logic                   hash_done;
    logic [IDX_W-1:0]       home_idx;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    lph_entry_t             wr_data;
    lph_entry_t             rd_data;
    logic                   key_match;
    logic [IDX_W-1:0]       idx_wrap;

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;

    // The key ends at its saturated length or at its first zero byte.
    always_comb begin
        limit      = (s_key_length > KEY_LIMIT) ? KEY_LIMIT : s_key_length;
        shaped_key = '0;
        shaped_len = '0;
        key_end    = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (!key_end && (KLEN_W'(i) < limit) && (s_key_bytes[i*BYTE_W +: BYTE_W] != '0)) begin
                shaped_key[i*BYTE_W +: BYTE_W] = s_key_bytes[i*BYTE_W +: BYTE_W];
                shaped_len = shaped_len + 1'b1;
            end else begin
                key_end = 1'b1;
            end
        end
    end

    // The home slot is worked out by the iterative hash and modulo unit.
    lph_hash_unit #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_hash (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (hash_start),
        .key      (shaped_key),
        .key_len  (shaped_len),
        .done     (hash_done),
        .home_idx (home_idx)
    );

    // The slot memory is read every cycle at the probe index; the registered data lands in the cycle after.
    lph_slot_mem #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign key_match = (rd_data.key_len == len_reg) && (rd_data.key == key_reg);
    assign idx_wrap  = (idx_reg == IDX_LAST) ? '0 : (idx_reg + 1'b1);
    assign wr_addr   = idx_reg;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        hash_start      = 1'b0;
        wr_en           = 1'b0;
        wr_data         = rd_data;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                // Mark every slot unused, one per cycle.
                wr_en   = 1'b1;
                wr_data = '0;
                if (idx_reg == IDX_LAST) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    cmd_next        = s_command;
                    key_next        = shaped_key;
                    len_next        = shaped_len;
                    value_next      = s_insert_value;
                    res_status_next = ST_OK;
                    res_value_next  = NO_VALUE;
                    if (s_command == CMD_NOP) begin
                        state_next = S_DONE;
                    end else if ((s_command == CMD_INSERT) && (count_reg >= COUNT_FULL)) begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end else begin
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    idx_next   = home_idx;
                    step_next  = '0;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (cmd_reg == CMD_INSERT) begin
                    if (!rd_data.used) begin
                        // First free slot on the chain takes the new entry.
                        wr_en           = 1'b1;
                        wr_data.used    = 1'b1;
                        wr_data.key_len = len_reg;
                        wr_data.key     = key_reg;
                        wr_data.value   = value_reg;
                        count_next      = count_reg + 1'b1;
                        state_next      = S_DONE;
                    end else if (step_reg == IDX_LAST) begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end else begin
                        idx_next   = idx_wrap;
                        step_next  = step_reg + 1'b1;
                        state_next = S_READ;
                    end
                end else begin
                    if (!rd_data.used) begin
                        // An empty slot ends the chain.
                        res_status_next = ST_MISSING;
                        state_next      = S_DONE;
                    end else if (key_match) begin
                        if (cmd_reg == CMD_LOOKUP) begin
                            res_value_next = rd_data.value;
                        end else begin
                            // Remove leaves no tombstone: the slot simply becomes unused.
                            wr_en        = 1'b1;
                            wr_data.used = 1'b0;
                            if (count_reg != '0) begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        state_next = S_DONE;
                    end else if (step_reg == IDX_LAST) begin
                        res_status_next = ST_MISSING;
                        state_next      = S_DONE;
                    end else begin
                        idx_next   = idx_wrap;
                        step_next  = step_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            step_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            step_reg    <= step_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        len_reg        <= len_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_read_value = m_value_reg;

endmodule
